/* rtl/cgba_pkg.sv */
// Shared types, constants and lookup functions for the command-gated block averager.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package cgba_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int BYTE_BITS     = 8;
  localparam int KIND_BITS     = 2;
  localparam int LINE_CAPACITY = 15;
  localparam int LINE_BITS     = $clog2(LINE_CAPACITY + 1);
  localparam int WINDOW_BITS   = 13;
  localparam int WINDOW_MAX    = 4096;
  localparam int WINDOW_RESET  = 1200;
  localparam int SUM_BITS      = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int DIV_STEPS     = SUM_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS + 1);
  localparam int QUEUE_DEPTH   = 2;  // power of two: pointers wrap naturally
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_BITS-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_BITS-1:0] PRINT_HI = 8'h7E;

  localparam int START_LEN = 5;
  localparam int STOP_LEN  = 4;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2
  } op_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_MEAN  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_DIVIDE
  } back_state_t;

  typedef struct packed {
    op_t                    op;
    logic [SAMPLE_BITS-1:0] sample;
  } entry_t;

  function automatic logic [BYTE_BITS-1:0] start_char(input logic [LINE_BITS-1:0] idx);
    logic [BYTE_BITS-1:0] c;
    case (idx)
      LINE_BITS'(0): c = "S";
      LINE_BITS'(1): c = "T";
      LINE_BITS'(2): c = "A";
      LINE_BITS'(3): c = "R";
      LINE_BITS'(4): c = "T";
      default:       c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_BITS-1:0] stop_char(input logic [LINE_BITS-1:0] idx);
    logic [BYTE_BITS-1:0] c;
    case (idx)
      LINE_BITS'(0): c = "S";
      LINE_BITS'(1): c = "T";
      LINE_BITS'(2): c = "O";
      LINE_BITS'(3): c = "P";
      default:       c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/cgba_ifs.sv */
// Channel interfaces: input items, result items and the configuration write.
// Depends on cgba_pkg for field widths.
`default_nettype none

interface cgba_item_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [cgba_pkg::SAMPLE_BITS-1:0]  sample;
  logic [cgba_pkg::BYTE_BITS-1:0]    rx_byte;
  modport source (output valid, func, sample, rx_byte, input ready);
  modport sink   (input valid, func, sample, rx_byte, output ready);
endinterface

interface cgba_result_if;
  logic                              valid;
  logic                              ready;
  logic [cgba_pkg::KIND_BITS-1:0]    kind;
  logic [cgba_pkg::SAMPLE_BITS-1:0]  mean;
  modport source (output valid, kind, mean, input ready);
  modport sink   (input valid, kind, mean, output ready);
endinterface

interface cgba_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cgba_pkg::WINDOW_BITS-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/cgba_queue.sv */
// Short FIFO of classified operations between the front and back ends.
// Depends on cgba_pkg for the entry type and depth.
`default_nettype none

module cgba_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  cgba_pkg::entry_t     push_entry,
  output logic                 full,
  input  wire                  pop,
  output cgba_pkg::entry_t     head,
  output logic                 nonempty
);

  cgba_pkg::entry_t                 entries [cgba_pkg::QUEUE_DEPTH];
  logic [cgba_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [cgba_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [cgba_pkg::QCNT_BITS-1:0]   count;

  assign full     = (count == cgba_pkg::QCNT_BITS'(cgba_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/cgba_front.sv */
// Front end: accepts items, tracks the command line and classifies each item.
// Depends on cgba_pkg and cgba_ifs; feeds cgba_queue.
`default_nettype none

module cgba_front (
  input  wire                  clk,
  input  wire                  rst,
  cgba_item_if.sink            items,
  input  wire                  q_full,
  output logic                 push,
  output cgba_pkg::entry_t     push_entry
);

  logic [cgba_pkg::LINE_BITS-1:0] line_length;
  logic                           start_ok;
  logic                           stop_ok;

  logic                           accept;
  logic                           printable;
  logic [cgba_pkg::LINE_BITS-1:0] len_inc;
  logic                           st_hit;
  logic                           sp_hit;
  logic                           is_start;
  logic                           is_stop;
  logic                           line_full;

  assign items.ready = !q_full;
  assign accept      = items.valid && items.ready;

  always_comb begin
    printable = (items.rx_byte >= cgba_pkg::PRINT_LO) && (items.rx_byte <= cgba_pkg::PRINT_HI);
    len_inc   = line_length + 1'b1;
    // prefix flags only count once the line holds at least one character
    st_hit    = (line_length < cgba_pkg::LINE_BITS'(cgba_pkg::START_LEN))
             && (items.rx_byte == cgba_pkg::start_char(line_length))
             && ((line_length == '0) || start_ok);
    sp_hit    = (line_length < cgba_pkg::LINE_BITS'(cgba_pkg::STOP_LEN))
             && (items.rx_byte == cgba_pkg::stop_char(line_length))
             && ((line_length == '0) || stop_ok);
    is_start  = st_hit && (len_inc == cgba_pkg::LINE_BITS'(cgba_pkg::START_LEN));
    is_stop   = sp_hit && (len_inc == cgba_pkg::LINE_BITS'(cgba_pkg::STOP_LEN));
    line_full = (len_inc == cgba_pkg::LINE_BITS'(cgba_pkg::LINE_CAPACITY));
  end

  always_comb begin
    push              = accept && (!items.func || (printable && (is_start || is_stop)));
    push_entry.sample = items.sample;
    if (!items.func) begin
      push_entry.op = cgba_pkg::OP_SAMPLE;
    end else if (is_start) begin
      push_entry.op = cgba_pkg::OP_START;
    end else begin
      push_entry.op = cgba_pkg::OP_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      start_ok    <= 1'b0;
      stop_ok     <= 1'b0;
    end else if (accept && items.func && printable) begin
      start_ok <= st_hit;
      stop_ok  <= sp_hit;
      // drop the line on a match or once it fills up
      if (is_start || is_stop || line_full) begin
        line_length <= '0;
      end else begin
        line_length <= len_inc;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/cgba_divider.sv */
// Restoring divider, one quotient bit per cycle, for the window mean.
// Depends on cgba_pkg for the sum and window widths.
`default_nettype none

module cgba_divider (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  input  wire [cgba_pkg::SUM_BITS-1:0]       dividend,
  input  wire [cgba_pkg::WINDOW_BITS-1:0]    divisor,
  output logic                               done,
  output logic [cgba_pkg::SUM_BITS-1:0]      quotient
);

  logic [cgba_pkg::WINDOW_BITS-1:0]   rem;
  logic [cgba_pkg::WINDOW_BITS-1:0]   dvs;
  logic [cgba_pkg::DIV_CNT_BITS-1:0]  cnt;
  logic [cgba_pkg::WINDOW_BITS:0]     trial;
  logic                               fits;

  always_comb begin
    trial = {rem, quotient[cgba_pkg::SUM_BITS-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (cnt != '0) begin
      quotient <= {quotient[cgba_pkg::SUM_BITS-2:0], fits};
      if (fits) begin
        rem <= cgba_pkg::WINDOW_BITS'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[cgba_pkg::WINDOW_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= cgba_pkg::DIV_CNT_BITS'(cgba_pkg::DIV_STEPS);
      done <= 1'b0;
    end else begin
      done <= (cnt == cgba_pkg::DIV_CNT_BITS'(1));
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/cgba_back.sv */
// Back end: runs queued operations, keeps the window sum and the enable flag,
// and owns the result register. Depends on cgba_pkg, cgba_ifs and cgba_divider.
`default_nettype none

module cgba_back (
  input  wire                              clk,
  input  wire                              rst,
  input  cgba_pkg::entry_t                 head,
  input  wire                              q_valid,
  output logic                             pop,
  input  wire [cgba_pkg::WINDOW_BITS-1:0]  window_length,
  cgba_result_if.source                    results
);

  cgba_pkg::back_state_t              state;
  cgba_pkg::back_state_t              state_next;
  logic                               enabled;
  logic [cgba_pkg::SUM_BITS-1:0]      sum;
  logic [cgba_pkg::WINDOW_BITS-1:0]   tally;
  logic                               out_valid;
  cgba_pkg::kind_t                    out_kind;
  logic [cgba_pkg::SAMPLE_BITS-1:0]   out_mean;

  logic [cgba_pkg::SUM_BITS-1:0]      sum_next;
  logic [cgba_pkg::WINDOW_BITS-1:0]   tally_next;
  logic [cgba_pkg::WINDOW_BITS-1:0]   win_eff;
  logic                               window_hit;
  logic                               slot_free;
  logic                               div_start;
  logic                               div_done;
  logic [cgba_pkg::SUM_BITS-1:0]      quotient;

  assign results.valid = out_valid;
  assign results.kind  = out_kind;
  assign results.mean  = out_mean;

  always_comb begin
    if (window_length == '0) begin
      win_eff = cgba_pkg::WINDOW_BITS'(1);
    end else if (window_length > cgba_pkg::WINDOW_BITS'(cgba_pkg::WINDOW_MAX)) begin
      win_eff = cgba_pkg::WINDOW_BITS'(cgba_pkg::WINDOW_MAX);
    end else begin
      win_eff = window_length;
    end
    sum_next   = sum + cgba_pkg::SUM_BITS'(head.sample);
    tally_next = tally + 1'b1;
    window_hit = (tally_next >= win_eff);
  end

  // outputs of the sequencer
  always_comb begin
    slot_free = !out_valid || results.ready;
    pop       = (state == cgba_pkg::BK_IDLE) && q_valid && slot_free;
    div_start = pop && (head.op == cgba_pkg::OP_SAMPLE) && enabled && window_hit;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cgba_pkg::BK_IDLE: begin
        if (div_start) begin
          state_next = cgba_pkg::BK_DIVIDE;
        end
      end
      cgba_pkg::BK_DIVIDE: begin
        if (div_done) begin
          state_next = cgba_pkg::BK_IDLE;
        end
      end
      default: state_next = cgba_pkg::BK_IDLE;
    endcase
  end

  cgba_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (tally_next),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cgba_pkg::BK_IDLE;
      enabled   <= 1'b0;
      sum       <= '0;
      tally     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        case (head.op)
          cgba_pkg::OP_SAMPLE: begin
            if (enabled) begin
              if (window_hit) begin
                sum   <= '0;
                tally <= '0;
              end else begin
                sum   <= sum_next;
                tally <= tally_next;
              end
            end
          end
          cgba_pkg::OP_START: begin
            enabled   <= 1'b1;
            out_valid <= 1'b1;
          end
          cgba_pkg::OP_STOP: begin
            enabled   <= 1'b0;
            sum       <= '0;
            tally     <= '0;
            out_valid <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if ((state == cgba_pkg::BK_DIVIDE) && div_done) begin
        out_valid <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop && (head.op == cgba_pkg::OP_START)) begin
      out_kind <= cgba_pkg::KIND_START;
      out_mean <= '0;
    end else if (pop && (head.op == cgba_pkg::OP_STOP)) begin
      out_kind <= cgba_pkg::KIND_STOP;
      out_mean <= '0;
    end else if ((state == cgba_pkg::BK_DIVIDE) && div_done) begin
      out_kind <= cgba_pkg::KIND_MEAN;
      out_mean <= quotient[cgba_pkg::SAMPLE_BITS-1:0];
    end
  end

  a_tally_bound: assert property (@(posedge clk) disable iff (rst)
    tally < cgba_pkg::WINDOW_BITS'(cgba_pkg::WINDOW_MAX))
    else $error("window tally reached the maximum window without emitting");

  a_no_pop_dividing: assert property (@(posedge clk) disable iff (rst)
    (state == cgba_pkg::BK_DIVIDE) |-> !pop)
    else $error("queue popped while a mean is being divided");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == cgba_pkg::BK_DIVIDE))
    else $error("divider finished outside the divide state");

  a_disabled_clear: assert property (@(posedge clk) disable iff (rst)
    !enabled |-> ((sum == '0) && (tally == '0)))
    else $error("sum or tally nonzero while sampling is disabled");

  a_slot_free_on_load: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !out_valid || (state == cgba_pkg::BK_DIVIDE))
    else $error("result register busy when a division started");

endmodule

`default_nettype wire

/* rtl/command_gated_block_averager_top.sv */
// Command-gated block averager: samples are averaged over a programmable
// window once a START command line is received, and STOP halts sampling.
// An item costs one cycle at the input while the two-entry operation queue
// has room. The back end retires one queued operation per cycle while the
// result register is free or being taken, except a sample that completes a
// window: it holds the back end through its own pop, the restoring divider
// working out the quotient bit by bit, and the loading of the result.
// During that time, and while a result waits to be taken, the front end keeps
// accepting items until the queue fills. Command bytes outside 0x20..0x7E are
// ignored; a line of 15 characters without a match is dropped. Window lengths
// of 0 act as 1 and values above 4096 act as 4096.
// Depends on cgba_pkg, cgba_ifs, cgba_front, cgba_queue, cgba_back.
`default_nettype none

module command_gated_block_averager_top (
  input  wire            clk,
  input  wire            rst,
  cgba_item_if.sink      items,
  cgba_result_if.source  results,
  cgba_cfg_if.sink       cfg
);

  logic [cgba_pkg::WINDOW_BITS-1:0] window_length;
  logic                             push;
  cgba_pkg::entry_t                 push_entry;
  logic                             q_full;
  logic                             pop;
  cgba_pkg::entry_t                 head;
  logic                             q_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= cgba_pkg::WINDOW_BITS'(cgba_pkg::WINDOW_RESET);
    end else if (cfg.valid && cfg.ready) begin
      window_length <= cfg.data;
    end
  end

  cgba_front u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  cgba_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .nonempty   (q_valid)
  );

  cgba_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_valid       (q_valid),
    .pop           (pop),
    .window_length (window_length),
    .results       (results)
  );

endmodule

`default_nettype wire
